FILE: src/imd_pkg.sv
// shared types and constants for the mod 65537 inverse block
package imd_pkg;

    localparam int WORD_W     = 16;
    localparam int DVD_W      = WORD_W + 1;
    localparam int DIV_STEPS  = DVD_W;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);
    localparam int MAX_PASSES = 32;
    localparam int PASS_W     = $clog2(MAX_PASSES);

    localparam logic [DVD_W-1:0]  MODULUS  = 17'h10001;
    localparam logic [WORD_W-1:0] WORD_ONE = 16'h0001;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT0,
        ST_START_A,
        ST_WAIT_A,
        ST_START_B,
        ST_WAIT_B,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
        logic [WORD_W-1:0] remainder;
    } div_rsp_t;

endpackage

FILE: src/imd_div.sv
// bit-serial restoring divider, 17-bit dividend by 16-bit divisor
module imd_div
    import imd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DVD_W-1:0]  trial;
    logic              fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so 16 bits hold it
            if (fits)
            begin
                rem_next = WORD_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[WORD_W-1:0];
            end
            // divisor is at least 2 whenever the dividend needs 17 bits,
            // so the quotient fits in 16 bits
            quo_next = {quo_reg[WORD_W-2:0], fits};
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: src/inverse_mod_65537.sv
// multiplicative inverse modulo 65537: sequencer, coefficient update and output register
//
// usage: one 16-bit word enters on the s_ group, its inverse modulo 65537
// leaves on the m_ group; the word 0 stands for 65536 on both sides.
// a transfer happens on a rising edge with tvalid and tready both high.
// s_tready is high only while the sequencer is idle; one word at a time.
// operands 0 and 1 skip the divider. other operands run an extended
// euclidean algorithm on one shared bit-serial divider: each division runs
// 17 divider steps plus issue and handoff, and one word needs one initial
// division plus two per pass for up to 32 passes; the sequencer finishes
// one word before it takes the next.
// coefficients are updated by one 16x16 multiply-add after each division but the first.
// the result sits in an output register; a new operand is taken while it
// waits, but the sequencer holds its next result until m_tready frees it.
// reset (rst_n low, asynchronous) drops any word in work and any
// pending result; no state carries from one word to the next.
module inverse_mod_65537
    import imd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,  // [15:0] operand
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_tdata   // [15:0] inverse
);

    state_t state_reg, state_next;

    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] c0_reg, c0_next;
    logic [WORD_W-1:0] c1_reg, c1_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic              out_vld_reg, out_vld_next;
    logic [WORD_W-1:0] out_reg, out_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic              in_xfer;
    logic              out_free;
    logic              load_out;
    logic              trivial;
    logic [WORD_W-1:0] mul_coef;
    logic [WORD_W-1:0] add_coef;
    logic [2*WORD_W-1:0] prod;
    logic [WORD_W-1:0] coef_upd;
    logic              rem_one;
    logic              rem_zero;
    logic              last_pass;

    imd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !out_vld_reg || m_tready;
    assign trivial   = (s_tdata <= WORD_ONE);
    assign rem_one   = (div_rsp.remainder == WORD_ONE);
    assign rem_zero  = (div_rsp.remainder == '0);
    assign last_pass = (pass_reg == PASS_W'(MAX_PASSES - 1));

    // shared multiply-add, only the low word of each coefficient is kept
    // first half of a pass updates c0 from c1, second half c1 from c0
    assign mul_coef = (state_reg == ST_WAIT_B) ? c0_reg : c1_reg;
    assign add_coef = (state_reg == ST_WAIT_B) ? c1_reg : c0_reg;
    assign prod     = div_rsp.quotient * mul_coef;
    assign coef_upd = add_coef + prod[WORD_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = trivial ? ST_FIN : ST_WAIT0;
                end
            end
            ST_WAIT0:
            begin
                if (div_rsp.done)
                begin
                    state_next = (rem_one || rem_zero) ? ST_FIN : ST_START_A;
                end
            end
            ST_START_A:
            begin
                state_next = ST_WAIT_A;
            end
            ST_WAIT_A:
            begin
                if (div_rsp.done)
                begin
                    state_next = (rem_one || rem_zero) ? ST_FIN : ST_START_B;
                end
            end
            ST_START_B:
            begin
                state_next = ST_WAIT_B;
            end
            ST_WAIT_B:
            begin
                if (div_rsp.done)
                begin
                    state_next = (rem_one || rem_zero || last_pass) ? ST_FIN : ST_START_A;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready         = 1'b0;
        load_out         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = MODULUS;
        div_req.divisor  = s_tdata;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                div_req.start = s_tvalid && !trivial;
            end
            ST_START_A:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {1'b0, a_reg};
                div_req.divisor  = b_reg;
            end
            ST_START_B:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {1'b0, b_reg};
                div_req.divisor  = a_reg;
            end
            ST_FIN:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // euclid datapath
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        c0_next   = c0_reg;
        c1_next   = c1_reg;
        res_next  = res_reg;
        pass_next = pass_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                a_next   = s_tdata;
                res_next = s_tdata;
            end
            ST_WAIT0:
            begin
                if (div_rsp.done)
                begin
                    c1_next   = div_rsp.quotient;
                    b_next    = div_rsp.remainder;
                    c0_next   = WORD_ONE;
                    pass_next = '0;
                    if (rem_one)
                    begin
                        res_next = WORD_ONE - div_rsp.quotient;
                    end
                    else
                    begin
                        res_next = '0;
                    end
                end
            end
            ST_WAIT_A:
            begin
                if (div_rsp.done)
                begin
                    a_next   = div_rsp.remainder;
                    c0_next  = coef_upd;
                    res_next = rem_one ? coef_upd : '0;
                end
            end
            ST_WAIT_B:
            begin
                if (div_rsp.done)
                begin
                    b_next    = div_rsp.remainder;
                    c1_next   = coef_upd;
                    pass_next = pass_reg + PASS_W'(1);
                    // pass limit ends like a remainder of one
                    res_next  = rem_zero ? '0 : (WORD_ONE - coef_upd);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        if (load_out)
        begin
            out_vld_next = 1'b1;
            out_next     = res_reg;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pass_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pass_reg    <= pass_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        c0_reg  <= c0_next;
        c1_reg  <= c1_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule

FILE: bench/inverse_mod_65537_checker.sv
// checker for the mod 65537 inverse block: watches both streams, predicts and compares
module inverse_mod_65537_checker
    import imd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,  // [15:0] operand
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [WORD_W-1:0] m_tdata,  // [15:0] inverse
    output int                failures,
    output int                pending
);

    typedef struct packed {
        logic [WORD_W-1:0] operand;
        logic [WORD_W-1:0] inverse;
    } inverse_entry_t;

    inverse_entry_t inverse_q[$];

    // extended euclid on 65537 and the operand, coefficients wrap at 2^16
    function automatic logic [WORD_W-1:0] mod_inverse(input logic [WORD_W-1:0] v);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] q;
        int          pass;
        if (v <= 16'd1)
            return v;
        c1 = (32'h10001 / v) & 32'hFFFF;
        b  = 32'h10001 % v;
        if (b == 32'd1)
            return 16'(32'd1 - c1);
        if (b == 32'd0)
            return '0;
        a  = {16'd0, v};
        c0 = 32'd1;
        for (pass = 0; pass < MAX_PASSES; pass++)
        begin
            q  = a / b;
            a  = a % b;
            c0 = (c0 + q * c1) & 32'hFFFF;
            if (a == 32'd1)
                return c0[WORD_W-1:0];
            if (a == 32'd0)
                return '0;
            q  = b / a;
            b  = b % a;
            c1 = (c1 + q * c0) & 32'hFFFF;
            if (b == 32'd1)
                return 16'(32'd1 - c1);
            if (b == 32'd0)
                return '0;
        end
        return 16'(32'd1 - c1);
    endfunction

    always @(posedge clk)
    begin
        inverse_entry_t oldest;
        inverse_entry_t fresh;
        if (!rst_n)
        begin
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            // result side first, an operand taken on this edge cannot be answered yet
            if (m_tvalid && m_tready)
            begin
                if (inverse_q.size() == 0)
                begin
                    $display("%0t: unexpected inverse transfer: expected none, got %h",
                             $time, m_tdata);
                    failures <= failures + 1;
                end
                else
                begin
                    oldest = inverse_q.pop_front();
                    if (m_tdata !== oldest.inverse)
                    begin
                        $display("%0t: inverse of %h: expected %h, got %h",
                                 $time, oldest.operand, oldest.inverse, m_tdata);
                        failures <= failures + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                fresh.operand = s_tdata;
                fresh.inverse = mod_inverse(s_tdata);
                inverse_q.push_back(fresh);
            end
            pending <= inverse_q.size();
        end
    end

endmodule

FILE: bench/inverse_mod_65537_tb.sv
// testbench top for the mod 65537 inverse block: clock, reset, stimulus and verdict
module inverse_mod_65537_tb;
    import imd_pkg::*;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [WORD_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [WORD_W-1:0] m_tdata;

    int failures;
    int pending;
    int send_idle  = 0;
    int recv_stall = 0;

    inverse_mod_65537 DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    inverse_mod_65537_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .failures (failures),
        .pending  (pending)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_operand(input logic [WORD_W-1:0] v);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int                send_pct [4];
        int                recv_pct [4];
        logic [WORD_W-1:0] directed [$];
        logic [WORD_W-1:0] operand;
        int                phase;
        int                n;
        send_pct = '{0, 46, 0, 20};
        recv_pct = '{0, 0, 46, 20};
        // zero and one pass through, powers of two hit a first remainder of one
        directed = '{16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0010,
                     16'h0100, 16'h4000, 16'h8000, 16'h8001, 16'hFFFF, 16'hFFFE,
                     16'h7FFF, 16'h5555, 16'hAAAA, 16'h0005, 16'h0007, 16'h1234,
                     16'hC350, 16'h00FF};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed[i])
            send_operand(directed[i]);
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle  = send_pct[phase];
            recv_stall = recv_pct[phase];
            for (n = 0; n < 225; n++)
            begin
                case ($urandom_range(9))
                    0:       operand = WORD_W'($urandom_range(15));
                    1:       operand = WORD_W'(1) << $urandom_range(15);
                    2:       operand = 16'hFFFF - WORD_W'($urandom_range(15));
                    default: operand = WORD_W'($urandom);
                endcase
                send_operand(operand);
            end
        end
        s_tvalid   <= 1'b0;
        recv_stall = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (500) @(posedge clk);
        if (failures == 0)
            $display("inverse_mod_65537 verification clean");
        else
            $display("inverse_mod_65537 verification failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("inverse_mod_65537 verification failed");
        $finish;
    end

endmodule

FILE: files.f
src/imd_pkg.sv
src/imd_div.sv
src/inverse_mod_65537.sv
bench/inverse_mod_65537_checker.sv
bench/inverse_mod_65537_tb.sv
